>>> src/piecewise_linear_interpolator_assert.svh
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH

// Implication checked on every clock, off during reset.
`define PLI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define PLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pli_pkg.sv
package pli_pkg;

    localparam int unsigned MaxPointsDefault = 16;

    localparam logic [1:0] CmdClear = 2'd0;
    localparam logic [1:0] CmdLoad  = 2'd1;
    localparam logic [1:0] CmdQuery = 2'd2;

    localparam logic [2:0] StOk     = 3'd0;
    localparam logic [2:0] StExtrap = 3'd1;
    localparam logic [2:0] StNotAsc = 3'd2;
    localparam logic [2:0] StFull   = 3'd3;
    localparam logic [2:0] StFew    = 3'd4;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] y_value;
        logic [2:0]         status;
    } t_out_item;

endpackage

>>> src/pli_ram.sv
module pli_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/pli_divider.sv
module pli_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [63:0]        i_num,
    input  logic [32:0]        i_den,
    output logic               o_busy,
    output logic [63:0]        o_quo
);

    logic [63:0] r_quo;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [33:0] w_shift;
    logic [34:0] w_diff;

    assign w_shift = {r_rem[32:0], r_quo[63]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd64;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[34]) begin
                r_rem <= w_diff[33:0];
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

>>> src/piecewise_linear_interpolator.sv
// Piecewise linear interpolator over up to MAX_POINTS Q16.16 breakpoints.
// One transaction at a time. Clear, the unused command and a query on fewer than two points go
// straight to the output state. A load reads the last stored point and checks it, then runs the
// bit-serial slope divider when it adds a segment. A query scans the stored x values one memory
// read per cycle, then reads the segment and runs one 32x33 multiply.
// The result is held in an output register; a new transaction is taken once it drains.
`include "piecewise_linear_interpolator_assert.svh"

module piecewise_linear_interpolator #(
    parameter int unsigned MAX_POINTS = pli_pkg::MaxPointsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  pli_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output pli_pkg::t_out_item o_data
);

    localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] MaxCount = CW'(MAX_POINTS);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_LRD    = 9'b000000010,
        S_LCHK   = 9'b000000100,
        S_DIV    = 9'b000001000,
        S_DIVEND = 9'b000010000,
        S_SCAN   = 9'b000100000,
        S_SEGRD  = 9'b001000000,
        S_MUL    = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state             r_state, n_state;
    pli_pkg::t_in_item  r_item;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_idx;
    logic [AW-1:0]      r_cidx;
    logic [AW-1:0]      r_seg;
    logic               r_scan_vld;
    logic               r_below;
    logic               r_above;
    logic signed [31:0] r_ys;
    logic signed [63:0] r_prod;
    logic               r_neg;
    logic               r_ovalid;
    pli_pkg::t_out_item r_odata;

    logic               w_we_pt, w_we_sl;
    logic [AW-1:0]      w_waddr_pt, w_raddr;
    logic signed [31:0] w_rx, w_ry, w_rs;
    logic               w_div_start, w_div_busy;
    logic [63:0]        w_num, w_quo;
    logic [32:0]        w_den;
    logic signed [32:0] w_dx, w_dy;
    logic signed [31:0] w_slope;
    logic signed [64:0] w_sum;
    logic               w_accept;
    logic [AW-1:0]      w_last;

    assign w_last   = AW'(r_count - CW'(1));
    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE) || (r_ovalid && i_stall);
    assign o_valid  = r_ovalid;
    assign o_data   = r_odata;

    pli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
        .i_clk(i_clk), .i_we(w_we_pt), .i_waddr(w_waddr_pt),
        .i_wdata(r_item.x_coord), .i_raddr(w_raddr), .o_rdata(w_rx)
    );
    pli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
        .i_clk(i_clk), .i_we(w_we_pt), .i_waddr(w_waddr_pt),
        .i_wdata(r_item.y_coord), .i_raddr(w_raddr), .o_rdata(w_ry)
    );
    pli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_s (
        .i_clk(i_clk), .i_we(w_we_sl), .i_waddr(w_last),
        .i_wdata(w_slope), .i_raddr(w_raddr), .o_rdata(w_rs)
    );

    assign w_waddr_pt = AW'(r_count);
    assign w_dx = 33'(r_item.x_coord) - 33'(w_rx);
    assign w_dy = 33'(r_item.y_coord) - 33'(w_ry);
    assign w_num = w_dy[32] ? 64'(-(64'(w_dy)) <<< 16) : (64'(w_dy) << 16);
    assign w_den = w_dx;
    assign w_div_start = (r_state == S_LCHK) && (r_count != '0)
        && (r_count != MaxCount) && !(r_item.x_coord <= w_rx);

    always_comb begin
        logic signed [64:0] q;
        q = r_neg ? -65'(w_quo) : 65'(w_quo);
        if (q > 65'sd2147483647) begin
            w_slope = 32'sh7fffffff;
        end else if (q < -65'sd2147483648) begin
            w_slope = 32'sh80000000;
        end else begin
            w_slope = q[31:0];
        end
    end

    assign w_we_sl = (r_state == S_DIVEND);
    assign w_we_pt = ((r_state == S_LCHK) && (r_count != MaxCount)
        && ((r_count == '0) || !(r_item.x_coord <= w_rx) && !w_div_start))
        || (r_state == S_DIVEND);

    always_comb begin
        case (r_state)
            S_SCAN:  w_raddr = r_idx;
            S_SEGRD: w_raddr = r_seg;
            default: w_raddr = w_last;
        endcase
    end

    assign w_sum = 65'(r_ys) + 65'(r_prod >>> 16);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_data.command)
                        pli_pkg::CmdLoad:  n_state = S_LRD;
                        pli_pkg::CmdQuery: n_state = (r_count < CW'(2)) ? S_OUT : S_SCAN;
                        default:           n_state = S_OUT;
                    endcase
                end
            end
            S_LRD:    n_state = S_LCHK;
            S_LCHK:   n_state = w_div_start ? S_DIV : S_OUT;
            S_DIV:    n_state = w_div_busy ? S_DIV : S_DIVEND;
            S_DIVEND: n_state = S_OUT;
            S_SCAN:   n_state = (r_scan_vld && (r_cidx == w_last)) ? S_SEGRD : S_SCAN;
            S_SEGRD:  n_state = S_MUL;
            S_MUL:    n_state = r_scan_vld ? S_OUT : S_MUL;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (w_accept && (i_data.command == pli_pkg::CmdClear)) begin
                r_count <= '0;
            end else if (w_we_pt) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item          <= i_data;
            r_odata.y_value <= '0;
            r_idx           <= '0;
            r_seg           <= '0;
            r_scan_vld      <= 1'b0;
            r_below         <= 1'b0;
            r_above         <= 1'b0;
            if (i_data.command == pli_pkg::CmdQuery && r_count < CW'(2)) begin
                r_odata.status <= pli_pkg::StFew;
            end else begin
                r_odata.status <= pli_pkg::StOk;
            end
        end
        if (r_state == S_LCHK) begin
            if (r_count == MaxCount) begin
                r_odata.status <= pli_pkg::StFull;
            end else if ((r_count != '0) && (r_item.x_coord <= w_rx)) begin
                r_odata.status <= pli_pkg::StNotAsc;
            end
            r_neg <= w_dy[32];
        end
        if (r_state == S_SCAN) begin
            r_cidx <= r_idx;
            if (r_idx != w_last) begin
                r_idx <= r_idx + AW'(1);
            end
            if (r_scan_vld) begin
                if (w_rx < r_item.x_coord) begin
                    r_seg <= (r_cidx > AW'(r_count - CW'(2))) ? AW'(r_count - CW'(2)) : r_cidx;
                end
                if ((r_cidx == '0) && (r_item.x_coord < w_rx)) begin
                    r_below <= 1'b1;
                end
                if ((r_cidx == w_last) && (r_item.x_coord > w_rx)) begin
                    r_above <= 1'b1;
                end
            end
            if (n_state == S_SEGRD) begin
                r_scan_vld <= 1'b0;
            end else begin
                r_scan_vld <= 1'b1;
            end
        end
        if (r_state == S_MUL) begin
            if (!r_scan_vld) begin
                r_ys       <= w_ry;
                r_prod     <= 64'(w_rs) * 64'(33'(r_item.x_coord) - 33'(w_rx));
                r_scan_vld <= 1'b1;
            end else begin
                if (w_sum > 65'sd2147483647) begin
                    r_odata.y_value <= 32'sh7fffffff;
                end else if (w_sum < -65'sd2147483648) begin
                    r_odata.y_value <= 32'sh80000000;
                end else begin
                    r_odata.y_value <= w_sum[31:0];
                end
                r_odata.status <= (r_below || r_above) ? pli_pkg::StExtrap : pli_pkg::StOk;
            end
        end
    end

    pli_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_num), .i_den(w_den), .o_busy(w_div_busy), .o_quo(w_quo)
    );

    `PLI_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !w_accept,
        "transaction accepted while busy")
    `PLI_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= MaxCount,
        "point count above table size")
    `PLI_ASSERT_NEXT(a_out_after, i_clk, i_rst_n, r_state == S_OUT, r_ovalid,
        "result not presented")

endmodule
